// ===== design/tdnp_pkg.sv =====
// Shared constants, types and state codes for the trial division prime block.
`timescale 1ns / 1ps

package tdnp_pkg;

  localparam int DataWidth  = 32;
  localparam int FieldWidth = 32;
  localparam int CntWidth   = $clog2(DataWidth + 1);
  localparam int InBytes    = (FieldWidth + 7) / 8;
  localparam int OutBits    = FieldWidth + 2;
  localparam int OutBytes   = (OutBits + 7) / 8;

  typedef logic [DataWidth-1:0]  word_t;
  typedef logic [FieldWidth-1:0] field_t;
  typedef logic [CntWidth-1:0]   cnt_t;

  localparam cnt_t  DivLast  = cnt_t'(DataWidth - 1);
  localparam word_t WordMax  = '1;
  localparam word_t FirstDiv = word_t'(2);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StStart,
    StDiv,
    StResult,
    StAdvance,
    StEmit
  } state_e;

endpackage

// ===== design/tdnp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tdnp_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tdnp_pkg::word_t dividend_i,
  input  tdnp_pkg::word_t divisor_i,
  output logic           done_o,
  output tdnp_pkg::word_t quotient_o,
  output tdnp_pkg::word_t remainder_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  tdnp_pkg::cnt_t  cnt_q, cnt_d;
  tdnp_pkg::word_t rem_q, rem_d;
  tdnp_pkg::word_t quo_q, quo_d;
  tdnp_pkg::word_t dvs_q, dvs_d;

  logic [tdnp_pkg::DataWidth:0] rem_sh;
  logic [tdnp_pkg::DataWidth:0] diff;
  logic                         ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[tdnp_pkg::DataWidth-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = ~diff[tdnp_pkg::DataWidth];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[tdnp_pkg::DataWidth-1:0] : rem_sh[tdnp_pkg::DataWidth-1:0];
      quo_d = {quo_q[tdnp_pkg::DataWidth-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tdnp_pkg::DivLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== design/trial_division_next_prime_top.sv =====
// Top level: sequencer for trial division primality test and next prime search.
`timescale 1ns / 1ps
// Each trial divisor takes one pass through the shared restoring divider.
// One beat at a time; the next beat is taken once the result is in the output register.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.

module trial_division_next_prime_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [tdnp_pkg::InBytes*8-1:0]    s_axis_tdata_i,   // value
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tdnp_pkg::OutBytes*8-1:0]   m_axis_tdata_o    // is_prime, next_prime, overflow
);

  tdnp_pkg::state_e state_q, state_d;
  tdnp_pkg::word_t  n_q, n_d;
  tdnp_pkg::word_t  d_q, d_d;
  logic             next_q, next_d;
  logic             flag_q, flag_d;
  logic             isprime_q, isprime_d;
  logic             ovf_q, ovf_d;
  logic             mvalid_q, mvalid_d;
  logic [tdnp_pkg::OutBytes*8-1:0] mdata_q, mdata_d;

  logic             div_start;
  logic             div_done;
  tdnp_pkg::word_t  div_quo;
  tdnp_pkg::word_t  div_rem;
  tdnp_pkg::field_t np_field;

  tdnp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    next_d    = next_q;
    flag_d    = flag_q;
    isprime_d = isprime_q;
    ovf_d     = ovf_q;
    mvalid_d  = mvalid_q & ~m_axis_tready_i;
    mdata_d   = mdata_q;
    div_start = 1'b0;
    s_axis_tready_o = 1'b0;
    np_field  = ovf_q ? '0 : tdnp_pkg::field_t'(n_q);

    unique case (state_q)
      tdnp_pkg::StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          n_d     = tdnp_pkg::word_t'(s_axis_tdata_i[tdnp_pkg::FieldWidth-1:0]);
          next_d  = 1'b0;
          state_d = tdnp_pkg::StCheck;
        end
      end
      tdnp_pkg::StCheck: begin
        d_d = tdnp_pkg::FirstDiv;
        if (n_q < tdnp_pkg::FirstDiv) begin
          flag_d  = 1'b0;
          state_d = tdnp_pkg::StResult;
        end else begin
          state_d = tdnp_pkg::StStart;
        end
      end
      tdnp_pkg::StStart: begin
        div_start = 1'b1;
        state_d   = tdnp_pkg::StDiv;
      end
      tdnp_pkg::StDiv: begin
        if (div_done) begin
          if (d_q > div_quo) begin
            flag_d  = 1'b1;
            state_d = tdnp_pkg::StResult;
          end else if (div_rem == '0) begin
            flag_d  = 1'b0;
            state_d = tdnp_pkg::StResult;
          end else begin
            d_d     = d_q + 1'b1;
            state_d = tdnp_pkg::StStart;
          end
        end
      end
      tdnp_pkg::StResult: begin
        if (!next_q) begin
          isprime_d = flag_q;
          state_d   = tdnp_pkg::StAdvance;
        end else if (flag_q) begin
          ovf_d   = 1'b0;
          state_d = tdnp_pkg::StEmit;
        end else begin
          state_d = tdnp_pkg::StAdvance;
        end
      end
      tdnp_pkg::StAdvance: begin
        if (n_q == tdnp_pkg::WordMax) begin
          ovf_d   = 1'b1;
          state_d = tdnp_pkg::StEmit;
        end else begin
          n_d     = n_q + 1'b1;
          next_d  = 1'b1;
          state_d = tdnp_pkg::StCheck;
        end
      end
      tdnp_pkg::StEmit: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = '0;
          mdata_d[0] = isprime_q;
          mdata_d[tdnp_pkg::FieldWidth:1] = np_field;
          mdata_d[tdnp_pkg::FieldWidth+1] = ovf_q;
          state_d  = tdnp_pkg::StIdle;
        end
      end
      default: state_d = tdnp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tdnp_pkg::StIdle;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    next_q    <= next_d;
    flag_q    <= flag_d;
    isprime_q <= isprime_d;
    ovf_q     <= ovf_d;
    mdata_q   <= mdata_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

endmodule

// ===== verif/trial_division_next_prime_top_test.sv =====
// Testbench for the trial division primality test and next prime search block.
`timescale 1ns / 1ps

module trial_division_next_prime_top_test;

  localparam int  LimitCycles = 20_000_000;
  localparam int  TailCycles  = 50;
  localparam int  NumRandom   = 80;

  typedef struct packed {
    logic             overflow;
    tdnp_pkg::field_t next_prime;
    logic             is_prime;
  } prime_res_t;

  typedef struct {
    tdnp_pkg::word_t value;
    bit              drain;
  } stim_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              src_valid = 1'b0;
  logic [tdnp_pkg::InBytes*8-1:0]    src_value = '0;
  logic                              s_axis_tready_o;
  logic                              m_axis_tvalid_o;
  logic                              sink_ready = 1'b1;
  logic [tdnp_pkg::OutBytes*8-1:0]   m_axis_tdata_o;

  stim_t      pending_q[$];
  prime_res_t expected_q[$];
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         src_wait = 0;
  int         sink_wait = 0;
  bit         src_quiet = 1'b0;
  bit         sink_quiet = 1'b0;

  trial_division_next_prime_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (src_value),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit prime_by_division(longint unsigned n);
    longint unsigned d;
    if (n < 64'd2) return 1'b0;
    for (d = 64'd2; d <= n / d; d++) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_res_t next_prime_after(tdnp_pkg::word_t value);
    longint unsigned cand;
    longint unsigned top;
    prime_res_t      r;
    top          = 64'(tdnp_pkg::WordMax);
    cand         = 64'(value);
    r.is_prime   = prime_by_division(64'(value));
    r.next_prime = '0;
    r.overflow   = 1'b1;
    while (cand < top) begin
      cand++;
      if (prime_by_division(cand)) begin
        r.next_prime = tdnp_pkg::field_t'(cand);
        r.overflow   = 1'b0;
        break;
      end
    end
    return r;
  endfunction

  // quiet stretches: no idling until the flag flips back
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic tdnp_pkg::word_t random_value();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return tdnp_pkg::word_t'($urandom_range(0, 255));
    if (pick < 18) return tdnp_pkg::word_t'($urandom_range(0, 4095));
    if (pick == 18) return tdnp_pkg::word_t'($urandom_range(0, 65535));
    return tdnp_pkg::word_t'($urandom_range(0, (1 << 20) - 1));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_cnt++;
  endtask

  // driver: one beat per pending item, random gap after each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && !(src_valid && !s_axis_tready_o)) begin
      if (src_valid) expected_q.push_back(next_prime_after(src_value));
      if (src_wait != 0) begin
        src_wait  <= src_wait - 1;
        src_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        src_valid <= 1'b0;
      end else if (pending_q[0].drain && expected_q.size() != 0) begin
        src_valid <= 1'b0;
      end else begin
        src_valid <= 1'b1;
        src_value <= pending_q[0].value;
        src_wait  <= draw_gap(src_quiet);
        void'(pending_q.pop_front());
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    prime_res_t got;
    prime_res_t want;
    int         w;
    if (rst_ni) begin
      if (m_axis_tvalid_o && sink_ready) begin
        got = m_axis_tdata_o[tdnp_pkg::OutBits-1:0];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(got), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.is_prime !== want.is_prime)
            report_mismatch("is_prime", 64'(got.is_prime), 64'(want.is_prime));
          if (got.next_prime !== want.next_prime)
            report_mismatch("next_prime", 64'(got.next_prime), 64'(want.next_prime));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
        end
        w = draw_gap(sink_quiet);
        if (w != 0) begin
          sink_ready <= 1'b0;
          sink_wait  <= w;
        end
      end else if (sink_wait != 0) begin
        sink_wait <= sink_wait - 1;
        if (sink_wait == 1) sink_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tdnp_pkg::word_t directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd8, 32'd13, 32'd23,
                 32'd24, 32'd25, 32'd49, 32'd121, 32'd1000, 32'd65521, 32'd65535,
                 32'd65536, 32'd1048575, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (directed[i]) pending_q.push_back(stim_t'{value: directed[i], drain: 1'b0});
    for (int i = 0; i < NumRandom; i++) begin
      pending_q.push_back(stim_t'{value: random_value(),
                                  drain: (i == 0 || i == NumRandom / 2)});
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || src_valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tdnp_pkg.sv
design/tdnp_div.sv
design/trial_division_next_prime_top.sv
verif/trial_division_next_prime_top_test.sv
